// File: hdl/slpwm_pkg.sv
// shared types, constants and lightness table for the staggered led pwm
`default_nettype none

package slpwm_pkg;

    localparam int CHANNELS = 4;
    localparam int SLOTS    = 4;
    localparam int DUTY_W   = 8;
    localparam int CH_W     = 2;
    localparam int STAGGER  = (1 << DUTY_W) / SLOTS;
    localparam logic [DUTY_W-1:0] MAX_DUTY = 8'd255;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_INC  = 2'd2,
        CMD_DEC  = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_CH_ENABLE = 1'b0,
        CFG_RUNNING   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_cmd              cmd;
        logic [CH_W-1:0]   channel;
        logic [DUTY_W-1:0] amount;
        logic              wrap;
    } t_item;

    typedef struct packed {
        logic [SLOTS-1:0]  pin_levels;
        logic [DUTY_W-1:0] target_duty;
        logic [DUTY_W-1:0] adjusted_duty;
    } t_result;

    localparam logic [DUTY_W-1:0] LIGHTNESS [256] = '{
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
        8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,
        8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,8'd5,8'd5,8'd6,8'd6,8'd6,8'd6,
        8'd6,8'd7,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,8'd10,8'd10,8'd11,
        8'd11,8'd11,8'd12,8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd14,8'd15,8'd15,8'd16,
        8'd16,8'd16,
        8'd17,8'd17,8'd18,8'd18,8'd19,8'd19,8'd20,8'd20,8'd21,8'd21,8'd22,8'd22,8'd23,8'd23,
        8'd24,8'd24,
        8'd25,8'd25,8'd26,8'd26,8'd27,8'd28,8'd28,8'd29,8'd29,8'd30,8'd31,8'd31,8'd32,8'd33,
        8'd33,8'd34,
        8'd35,8'd35,8'd36,8'd37,8'd37,8'd38,8'd39,8'd40,8'd40,8'd41,8'd42,8'd43,8'd44,8'd44,
        8'd45,8'd46,
        8'd47,8'd48,8'd49,8'd49,8'd50,8'd51,8'd52,8'd53,8'd54,8'd55,8'd56,8'd57,8'd58,8'd59,
        8'd60,8'd61,
        8'd62,8'd63,8'd64,8'd65,8'd66,8'd67,8'd68,8'd69,8'd70,8'd71,8'd72,8'd73,8'd75,8'd76,
        8'd77,8'd78,
        8'd79,8'd80,8'd82,8'd83,8'd84,8'd85,8'd87,8'd88,8'd89,8'd90,8'd92,8'd93,8'd94,8'd96,
        8'd97,8'd99,
        8'd100,8'd101,8'd103,8'd104,8'd106,8'd107,8'd108,8'd110,8'd111,8'd113,8'd114,8'd116,
        8'd118,8'd119,8'd121,8'd122,
        8'd124,8'd125,8'd127,8'd129,8'd130,8'd132,8'd134,8'd135,8'd137,8'd139,8'd141,8'd142,
        8'd144,8'd146,8'd148,8'd149,
        8'd151,8'd153,8'd155,8'd157,8'd159,8'd161,8'd162,8'd164,8'd166,8'd168,8'd170,8'd172,
        8'd174,8'd176,8'd178,8'd180,
        8'd182,8'd185,8'd187,8'd189,8'd191,8'd193,8'd195,8'd197,8'd200,8'd202,8'd204,8'd206,
        8'd208,8'd211,8'd213,8'd215,
        8'd218,8'd220,8'd222,8'd225,8'd227,8'd230,8'd232,8'd234,8'd237,8'd239,8'd242,8'd244,
        8'd247,8'd249,8'd252,8'd255
    };

endpackage

`default_nettype wire

// File: hdl/slpwm_in_stage.sv
// input register stage: captures one command beat
`default_nettype none

module slpwm_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    input  wire                 i_item_load,     // downstream side can take the held beat
    input  slpwm_pkg::t_item    i_item,
    output logic                o_s_tready,
    output logic                o_valid,
    output slpwm_pkg::t_item    o_item
);

    logic             r_valid;
    slpwm_pkg::t_item r_item;

    assign o_s_tready = !r_valid || i_item_load;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: hdl/slpwm_core.sv
// channel state, duty update, pwm tick and result register
`default_nettype none

module slpwm_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  slpwm_pkg::t_cfg_idx                 i_cfg_idx,
    input  wire [slpwm_pkg::SLOTS-1:0]          i_cfg_wdata,
    input  wire                                 i_item_valid,
    input  slpwm_pkg::t_item                    i_item,
    input  wire                                 i_m_tready,
    output logic                                o_item_load,
    output logic                                o_res_valid,
    output slpwm_pkg::t_result                  o_res
);

    logic [slpwm_pkg::SLOTS-1:0]  r_enable;
    logic                         r_running;
    logic [slpwm_pkg::DUTY_W-1:0] r_target [slpwm_pkg::SLOTS];
    logic [slpwm_pkg::DUTY_W-1:0] r_adj    [slpwm_pkg::SLOTS];
    logic [slpwm_pkg::DUTY_W-1:0] r_off    [slpwm_pkg::SLOTS];
    logic [slpwm_pkg::DUTY_W-1:0] r_phase;
    logic [slpwm_pkg::SLOTS-1:0]  r_level;
    logic                         r_res_valid;
    slpwm_pkg::t_result           r_res;

    logic [slpwm_pkg::SLOTS-1:0]  n_level;
    logic [slpwm_pkg::DUTY_W-1:0] n_phase;
    logic [slpwm_pkg::DUTY_W-1:0] n_target;
    logic [slpwm_pkg::DUTY_W-1:0] n_adj;
    logic [slpwm_pkg::DUTY_W-1:0] n_off;
    logic [slpwm_pkg::SLOTS-1:0]  assigned;
    logic                         ch_assigned;
    logic                         do_update;
    logic                         do_tick;
    logic [slpwm_pkg::DUTY_W:0]   sum;
    logic [slpwm_pkg::DUTY_W-1:0] cur;
    logic [slpwm_pkg::DUTY_W-1:0] on_pt;
    slpwm_pkg::t_result           n_res;

    assign o_item_load = !r_res_valid || i_m_tready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        for (int c = 0; c < slpwm_pkg::SLOTS; c++) begin
            assigned[c] = (c < slpwm_pkg::CHANNELS) && r_enable[c];
        end
    end

    assign ch_assigned = assigned[i_item.channel];
    assign do_tick     = o_item_load && i_item_valid && (i_item.cmd == slpwm_pkg::CMD_TICK)
                         && r_running;
    assign do_update   = o_item_load && i_item_valid && (i_item.cmd != slpwm_pkg::CMD_TICK)
                         && ch_assigned;

    // new target for the addressed channel
    always_comb begin
        cur = r_target[i_item.channel];
        sum = {1'b0, cur} + {1'b0, i_item.amount};
        case (i_item.cmd)
            slpwm_pkg::CMD_SET: begin
                n_target = i_item.amount;
            end
            slpwm_pkg::CMD_INC: begin
                if (!i_item.wrap && sum[slpwm_pkg::DUTY_W]) begin
                    n_target = slpwm_pkg::MAX_DUTY;
                end else begin
                    n_target = sum[slpwm_pkg::DUTY_W-1:0];
                end
            end
            slpwm_pkg::CMD_DEC: begin
                if (!i_item.wrap && (i_item.amount >= cur)) begin
                    n_target = '0;
                end else begin
                    n_target = cur - i_item.amount;
                end
            end
            default: begin
                n_target = cur;
            end
        endcase
        n_adj = slpwm_pkg::LIGHTNESS[n_target];
        on_pt = slpwm_pkg::DUTY_W'(int'(i_item.channel) * slpwm_pkg::STAGGER);
        n_off = on_pt + n_adj;
    end

    // pwm compare, one channel per bit, off point wins over on point
    always_comb begin
        n_level = r_level;
        for (int c = 0; c < slpwm_pkg::SLOTS; c++) begin
            if (assigned[c]) begin
                if (r_off[c] == r_phase) begin
                    n_level[c] = 1'b0;
                end else if (slpwm_pkg::DUTY_W'(c * slpwm_pkg::STAGGER) == r_phase) begin
                    n_level[c] = 1'b1;
                end
            end
        end
        n_phase = r_phase + slpwm_pkg::DUTY_W'(1);
    end

    always_comb begin
        n_res.pin_levels = do_tick ? n_level : r_level;
        if (!ch_assigned) begin
            n_res.target_duty   = '0;
            n_res.adjusted_duty = '0;
        end else if (do_update) begin
            n_res.target_duty   = n_target;
            n_res.adjusted_duty = n_adj;
        end else begin
            n_res.target_duty   = r_target[i_item.channel];
            n_res.adjusted_duty = r_adj[i_item.channel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= '0;
            r_running   <= 1'b0;
            r_phase     <= '0;
            r_level     <= '0;
            r_res_valid <= 1'b0;
            for (int c = 0; c < slpwm_pkg::SLOTS; c++) begin
                r_target[c] <= '0;
                r_adj[c]    <= '0;
                r_off[c]    <= slpwm_pkg::DUTY_W'(c * slpwm_pkg::STAGGER);
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    slpwm_pkg::CFG_CH_ENABLE: r_enable  <= i_cfg_wdata;
                    slpwm_pkg::CFG_RUNNING:   r_running <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (do_tick) begin
                r_level <= n_level;
                r_phase <= n_phase;
            end
            if (do_update) begin
                r_target[i_item.channel] <= n_target;
                r_adj[i_item.channel]    <= n_adj;
                r_off[i_item.channel]    <= n_off;
            end
            if (o_item_load) begin
                r_res_valid <= i_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_load && i_item_valid) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// File: hdl/staggered_led_pwm_with_lightness_lut_top.sv
// top level of the four-channel staggered led pwm with lightness correction
//
//  channel | direction | signals                              | beat contents
//  --------+-----------+--------------------------------------+------------------------------
//  s       | in        | i_s_tvalid/o_s_tready/i_s_tdata/user | one command
//  m       | out       | o_m_tvalid/i_m_tready/o_m_tdata      | levels and addressed duties
//  cfg     | in        | i_cfg_we/i_cfg_idx/i_cfg_wdata       | register write, no read-back
//
// one beat per clock sustained while the result side is not stalled; an accepted beat
// passes the input register, then the update/compare logic into the result register,
// from which its result is offered on the m channel
// reset is synchronous, active low: stores cleared, off points at channel * 64
// a stall on the result side holds the result register and then the input
// register; a new beat is still taken while a result waits only if the input
// register is empty
`default_nettype none

module staggered_led_pwm_with_lightness_lut_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // command stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [1:0] channel, [9:2] amount, [10] wrap, rest zero
    input  wire  [1:0]  i_s_tuser,   // [1:0] cmd
    // result stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // [3:0] pin_levels, [11:4] target_duty, [19:12] adjusted
    // configuration writes
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,   // 0 channel_enable, 1 pwm_running
    input  wire  [3:0]  i_cfg_wdata
);

    slpwm_pkg::t_item   in_item;
    slpwm_pkg::t_item   held_item;
    slpwm_pkg::t_result res;
    logic               held_valid;
    logic               item_load;

    // unpack the command beat
    assign in_item.cmd     = slpwm_pkg::t_cmd'(i_s_tuser);
    assign in_item.channel = i_s_tdata[1:0];
    assign in_item.amount  = i_s_tdata[9:2];
    assign in_item.wrap    = i_s_tdata[10];

    slpwm_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_item_load (item_load),
        .i_item      (in_item),
        .o_s_tready  (o_s_tready),
        .o_valid     (held_valid),
        .o_item      (held_item)
    );

    slpwm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (slpwm_pkg::t_cfg_idx'(i_cfg_idx)),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (held_valid),
        .i_item       (held_item),
        .i_m_tready   (i_m_tready),
        .o_item_load  (item_load),
        .o_res_valid  (o_m_tvalid),
        .o_res        (res)
    );

    // pack the result beat, upper four bits padded with zeros
    assign o_m_tdata = {4'b0000, res.adjusted_duty, res.target_duty, res.pin_levels};

endmodule

`default_nettype wire
